// ===== src/bfs_pkg.sv =====
// Shared types and constants of the battery fault supervisor.
package bfs_pkg;

    // System state machine
    typedef enum logic [1:0] {
        ST_PRE_INIT = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_CHARGING = 2'd2,
        ST_ERRORED  = 2'd3
    } t_sys_state;

    // Aggregate module state codes
    localparam logic [1:0] SUM_IDLE      = 2'd0;
    localparam logic [1:0] SUM_BALANCING = 2'd1;
    localparam logic [1:0] SUM_FAULT     = 2'd2;

    // Live module state codes as reported
    localparam logic [1:0] MODE_IDLE      = 2'd0;
    localparam logic [1:0] MODE_BALANCING = 2'd1;
    localparam logic [1:0] MODE_FAULT     = 2'd2;

    // Error mask bit positions
    localparam int ERR_OVERTEMP  = 0;
    localparam int ERR_TIMEOUT   = 1;
    localparam int ERR_BATT_FLT  = 2;
    localparam int ERR_CURR_FLT  = 3;
    localparam int ERR_MODULE    = 4;
    localparam int ERR_BUS_A     = 5;
    localparam int ERR_BUS_B     = 6;
    localparam int ERR_W         = 7;

    localparam logic [7:0] NO_MODULE = 8'hFF;
    localparam int         CURSOR_W  = 5;

    // Configuration register indexes
    localparam int         CFG_IDX_W             = 3;
    localparam logic [2:0] CFG_CHECK_ENABLE      = 3'd0;
    localparam logic [2:0] CFG_TEMP_LIMIT        = 3'd1;
    localparam logic [2:0] CFG_HEARTBEAT_TIMEOUT = 3'd2;
    localparam logic [2:0] CFG_FAULT_GRACE       = 3'd3;
    localparam logic [2:0] CFG_CHARGE_IDLE_LIMIT = 3'd4;
    localparam int         CFG_DATA_W            = 32;

    typedef struct packed {
        logic [ERR_W-1:0]   check_enable;
        logic signed [15:0] temp_limit;
        logic [31:0]        heartbeat_timeout;
        logic [31:0]        fault_grace;
        logic [7:0]         charge_idle_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        check_enable:      7'h7F,
        temp_limit:        16'sd600,
        heartbeat_timeout: 32'd1000,
        fault_grace:       32'd1000,
        charge_idle_limit: 8'd10
    };

    // One module report as held in the input register
    typedef struct packed {
        logic [31:0]        now_ticks;
        logic [31:0]        heartbeat_time;
        logic [15:0]        fault_tally;
        logic [1:0]         module_mode;
        logic               last_module;
        logic signed [15:0] pack_temp;
        logic               batt_floating;
        logic               current_floating;
        logic               bus_a_error;
        logic               bus_b_error;
        logic               subsystems_ready;
        logic               charge_request;
    } t_report;

    // Per-tick accumulation handed from the module tracker to the state machine
    typedef struct packed {
        logic [ERR_W-1:0] errors;
        logic [7:0]       fault_module;
        logic [1:0]       summary;
    } t_tick_acc;

    localparam t_tick_acc ACC_IDLE = '{
        errors:       '0,
        fault_module: NO_MODULE,
        summary:      SUM_IDLE
    };

    // One status word
    typedef struct packed {
        t_sys_state       system_state;
        logic [ERR_W-1:0] error_mask;
        logic [7:0]       fault_module;
        logic [1:0]       module_summary;
        logic             fault_line_ok;
    } t_status;

endpackage

// ===== src/bfs_track.sv =====
// Per-module checks: heartbeat timeout, fault grace table and state aggregation.
module bfs_track #(
    parameter int MODULES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  bfs_pkg::t_report   i_rpt,
    input  bfs_pkg::t_cfg      i_cfg,
    output bfs_pkg::t_tick_acc o_acc
);
    import bfs_pkg::*;

    localparam int IDX_W = (MODULES > 1) ? $clog2(MODULES) : 1;

    logic [CURSOR_W-1:0] r_cursor;
    logic [MODULES-1:0]  r_pending;
    logic [MODULES-1:0]  n_pending;
    logic [31:0]         r_start [MODULES];
    t_tick_acc           r_acc;
    t_tick_acc           n_acc;

    logic [IDX_W-1:0] idx;
    logic             in_range;
    logic             pend;
    logic             faulting;
    logic             start_we;
    logic [31:0]      start_eff;
    logic [31:0]      hb_age;
    logic [31:0]      fault_age;

    assign idx      = r_cursor[IDX_W-1:0];
    assign in_range = ({1'b0, r_cursor} < 6'(MODULES));
    assign pend     = r_pending[idx];
    assign faulting = (i_rpt.fault_tally != '0);
    // A fault first seen on this report starts its grace period now.
    assign start_eff = pend ? r_start[idx] : i_rpt.now_ticks;
    assign fault_age = i_rpt.now_ticks - start_eff;
    assign hb_age    = i_rpt.now_ticks - i_rpt.heartbeat_time;

    always_comb begin
        n_acc     = r_acc;
        n_pending = r_pending;
        start_we  = 1'b0;
        if (in_range) begin
            if (i_cfg.check_enable[ERR_TIMEOUT] && (hb_age > i_cfg.heartbeat_timeout)) begin
                n_acc.errors[ERR_TIMEOUT] = 1'b1;
            end
            if (i_cfg.check_enable[ERR_MODULE]) begin
                if (faulting) begin
                    if (!pend) begin
                        n_pending[idx] = 1'b1;
                        start_we       = 1'b1;
                    end
                    if (fault_age >= i_cfg.fault_grace) begin
                        n_acc.errors[ERR_MODULE] = 1'b1;
                        if (r_acc.fault_module == NO_MODULE) begin
                            n_acc.fault_module = 8'(r_cursor);
                        end
                        n_acc.summary = SUM_FAULT;
                    end
                end else begin
                    n_pending[idx] = 1'b0;
                end
                if (i_rpt.module_mode == MODE_FAULT) begin
                    n_acc.summary = SUM_FAULT;
                end else if ((i_rpt.module_mode == MODE_BALANCING) &&
                             (n_acc.summary != SUM_FAULT)) begin
                    n_acc.summary = SUM_BALANCING;
                end
            end
        end
    end

    assign o_acc = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_pending <= '0;
            r_acc     <= ACC_IDLE;
        end else if (i_step) begin
            r_pending <= n_pending;
            if (i_rpt.last_module) begin
                r_cursor <= '0;
                r_acc    <= ACC_IDLE;
            end else begin
                r_cursor <= r_cursor + 1'b1;
                r_acc    <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && start_we) begin
            r_start[idx] <= i_rpt.now_ticks;
        end
    end

endmodule

// ===== src/bfs_fsm.sv =====
// System-level checks, system state machine and charge-request watchdog.
module bfs_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  bfs_pkg::t_report   i_rpt,
    input  bfs_pkg::t_cfg      i_cfg,
    input  bfs_pkg::t_tick_acc i_acc,
    output bfs_pkg::t_status   o_status
);
    import bfs_pkg::*;

    t_sys_state       r_state;
    t_sys_state       n_state;
    logic [7:0]       r_idle_cnt;
    logic [7:0]       n_idle_cnt;
    logic [ERR_W-1:0] errs;
    logic             any_err;

    always_comb begin
        errs = i_acc.errors;
        if (i_cfg.check_enable[ERR_OVERTEMP] && (i_rpt.pack_temp > i_cfg.temp_limit)) begin
            errs[ERR_OVERTEMP] = 1'b1;
        end
        if (i_cfg.check_enable[ERR_BATT_FLT] && i_rpt.batt_floating) begin
            errs[ERR_BATT_FLT] = 1'b1;
        end
        if (i_cfg.check_enable[ERR_CURR_FLT] && i_rpt.current_floating) begin
            errs[ERR_CURR_FLT] = 1'b1;
        end
        if (i_cfg.check_enable[ERR_BUS_A] && i_rpt.bus_a_error) begin
            errs[ERR_BUS_A] = 1'b1;
        end
        if (i_cfg.check_enable[ERR_BUS_B] && i_rpt.bus_b_error) begin
            errs[ERR_BUS_B] = 1'b1;
        end
    end

    assign any_err = (errs != '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_PRE_INIT: begin
                if (i_rpt.subsystems_ready) begin
                    n_state = any_err ? ST_ERRORED : ST_RUNNING;
                end
            end
            ST_RUNNING: begin
                if (any_err) begin
                    n_state = ST_ERRORED;
                end else if (i_rpt.charge_request) begin
                    n_state = ST_CHARGING;
                end
            end
            ST_CHARGING: begin
                if (any_err || (r_idle_cnt > i_cfg.charge_idle_limit)) begin
                    n_state = ST_ERRORED;
                end
            end
            ST_ERRORED: begin
                if (!any_err) begin
                    n_state = ST_RUNNING;
                end
            end
            default: n_state = r_state;
        endcase
    end

    // The watchdog counts ticks without a charge request while charging and saturates.
    always_comb begin
        n_idle_cnt = r_idle_cnt;
        case (r_state)
            ST_RUNNING: begin
                if (!any_err && i_rpt.charge_request) begin
                    n_idle_cnt = '0;
                end
            end
            ST_CHARGING: begin
                if (!any_err && (r_idle_cnt <= i_cfg.charge_idle_limit)) begin
                    if (i_rpt.charge_request) begin
                        n_idle_cnt = '0;
                    end else if (r_idle_cnt != 8'hFF) begin
                        n_idle_cnt = r_idle_cnt + 1'b1;
                    end
                end
            end
            default: n_idle_cnt = r_idle_cnt;
        endcase
    end

    always_comb begin
        o_status.system_state   = n_state;
        o_status.error_mask     = errs;
        o_status.fault_module   = i_acc.fault_module;
        o_status.module_summary = i_acc.summary;
        o_status.fault_line_ok  = (n_state != ST_ERRORED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_PRE_INIT;
            r_idle_cnt <= '0;
        end else if (i_step) begin
            r_state    <= n_state;
            r_idle_cnt <= n_idle_cnt;
        end
    end

endmodule

// ===== src/battery_fault_supervisor.sv =====
// Battery fault supervisor: top level with input word register and status register.
//
// Usage:
// Each refresh tick is sent on the input channel as one word per battery module,
// in module order, the final word with last_module set. System-level flags are
// taken from that final word only. A word is accepted when i_in_valid is high
// and o_in_stall is low; one word can be accepted in every cycle.
// Each accepted word is held in the input register; from there the per-module
// checks and, on the final word, the system state machine run combinationally
// and the status word is loaded into the output register. A status word is thus
// presented from the output register once its final input word leaves the input
// register, and words other than the final one produce no output.
// The output channel holds its word while i_out_stall is high; the input
// register keeps advancing non-final words meanwhile, and stalls only when a
// final word is waiting for the output register.
// Configuration writes take effect at the clock edge where i_cfg_we is high
// and should be made only while the block is idle.
// Synchronous reset clears both registers' valid flags, the module cursor,
// the fault-pending flags, the tick accumulators and the state machine
// (pre-init), and restores the configuration defaults.
module battery_fault_supervisor #(
    parameter int MODULES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bfs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bfs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [31:0]                         i_now_ticks,
    input  logic [31:0]                         i_heartbeat_time,
    input  logic [15:0]                         i_fault_tally,
    input  logic [1:0]                          i_module_mode,
    input  logic                                i_last_module,
    input  logic signed [15:0]                  i_pack_temp,
    input  logic                                i_batt_floating,
    input  logic                                i_current_floating,
    input  logic                                i_bus_a_error,
    input  logic                                i_bus_b_error,
    input  logic                                i_subsystems_ready,
    input  logic                                i_charge_request,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_system_state,
    output logic [bfs_pkg::ERR_W-1:0]           o_error_mask,
    output logic [7:0]                          o_fault_module,
    output logic [1:0]                          o_module_summary,
    output logic                                o_fault_line_ok
);
    import bfs_pkg::*;

    t_cfg      r_cfg;
    t_report   r_in;
    logic      r_in_valid;
    t_status   r_out;
    logic      r_out_valid;
    t_tick_acc acc;
    t_status   status;
    logic      in_accept;
    logic      advance;
    logic      close_tick;

    // The held word moves on unless it closes a tick and the status register is blocked.
    assign advance    = r_in_valid && (!r_in.last_module || !r_out_valid || !i_out_stall);
    assign close_tick = advance && r_in.last_module;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHECK_ENABLE:      r_cfg.check_enable      <= i_cfg_data[ERR_W-1:0];
                CFG_TEMP_LIMIT:        r_cfg.temp_limit        <= $signed(i_cfg_data[15:0]);
                CFG_HEARTBEAT_TIMEOUT: r_cfg.heartbeat_timeout <= i_cfg_data[31:0];
                CFG_FAULT_GRACE:       r_cfg.fault_grace       <= i_cfg_data[31:0];
                CFG_CHARGE_IDLE_LIMIT: r_cfg.charge_idle_limit <= i_cfg_data[7:0];
                default:               r_cfg                   <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.now_ticks        <= i_now_ticks;
            r_in.heartbeat_time   <= i_heartbeat_time;
            r_in.fault_tally      <= i_fault_tally;
            r_in.module_mode      <= i_module_mode;
            r_in.last_module      <= i_last_module;
            r_in.pack_temp        <= i_pack_temp;
            r_in.batt_floating    <= i_batt_floating;
            r_in.current_floating <= i_current_floating;
            r_in.bus_a_error      <= i_bus_a_error;
            r_in.bus_b_error      <= i_bus_b_error;
            r_in.subsystems_ready <= i_subsystems_ready;
            r_in.charge_request   <= i_charge_request;
        end
    end

    bfs_track #(
        .MODULES (MODULES)
    ) u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_rpt   (r_in),
        .i_cfg   (r_cfg),
        .o_acc   (acc)
    );

    bfs_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (close_tick),
        .i_rpt    (r_in),
        .i_cfg    (r_cfg),
        .i_acc    (acc),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (close_tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (close_tick) begin
            r_out <= status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_system_state   = r_out.system_state;
    assign o_error_mask     = r_out.error_mask;
    assign o_fault_module   = r_out.fault_module;
    assign o_module_summary = r_out.module_summary;
    assign o_fault_line_ok  = r_out.fault_line_ok;

endmodule

// ===== src/bfs_checker.sv =====
// Port-level assertions for the battery fault supervisor, bound to its top level.
module bfs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [1:0]                     o_system_state,
    input logic [bfs_pkg::ERR_W-1:0]      o_error_mask,
    input logic [7:0]                     o_fault_module,
    input logic [1:0]                     o_module_summary,
    input logic                           o_fault_line_ok
);
    import bfs_pkg::*;

    // No status word can be pending in the cycle after a reset edge.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("status word valid straight after reset");

    // The fault line follows the reported state.
    a_fault_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fault_line_ok == (o_system_state != ST_ERRORED)))
        else $error("fault line disagrees with system state");

    // A latched module is named exactly when the module-fault bit is set.
    a_fault_module: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_fault_module != NO_MODULE) == o_error_mask[ERR_MODULE]))
        else $error("fault module and module-fault bit disagree");

    // A latched module fault forces the fault summary.
    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_mask[ERR_MODULE]) |-> (o_module_summary == SUM_FAULT))
        else $error("module fault without fault summary");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_system_state) &&
            $stable(o_error_mask) && $stable(o_fault_module) &&
            $stable(o_module_summary) && $stable(o_fault_line_ok)))
        else $error("stalled status word changed");

endmodule

bind battery_fault_supervisor bfs_checker u_bfs_checker (.*);

// ===== test/battery_fault_supervisor_tb.sv =====
// Self-checking testbench for the battery fault supervisor: predicted status words vs DUT.
`timescale 1ns / 100ps

module battery_fault_supervisor_tb;
    import bfs_pkg::*;

    localparam int         MODULES        = 8;
    localparam logic [1:0] MODE_OTHER     = 2'd3;
    localparam int         HOLD_CYCLES    = 200;
    // The longest quiet stretch of a correct run is the receiver hold-off plus a few
    // sender gaps, so ten times that is ample.
    localparam int         WATCHDOG_LIMIT = 2000;

    // Predicts one status word per closed tick and checks the DUT's words in order.
    class status_scoreboard;
        t_cfg                cfg;
        t_sys_state          state;
        logic [7:0]          idle_ticks;
        bit                  pending[MODULES];
        logic [31:0]         started[MODULES];
        logic [CURSOR_W-1:0] cursor;
        logic [ERR_W-1:0]    tick_err;
        logic [7:0]          tick_fault;
        logic [1:0]          tick_sum;
        t_status             expected_status[$];
        int                  failures;
        int                  checked;
        int                  ticks_closed;

        function new();
            cfg          = CFG_RESET;
            state        = ST_PRE_INIT;
            idle_ticks   = '0;
            cursor       = '0;
            tick_err     = '0;
            tick_fault   = NO_MODULE;
            tick_sum     = SUM_IDLE;
            failures     = 0;
            checked      = 0;
            ticks_closed = 0;
            foreach (pending[m]) begin
                pending[m] = 1'b0;
                started[m] = '0;
            end
        endfunction

        function void note_word(t_report r);
            logic [CURSOR_W-1:0] idx;
            logic [31:0]         age;
            logic [ERR_W-1:0]    errs;
            t_sys_state          nxt;
            idx = cursor;
            if (idx < MODULES) begin
                age = r.now_ticks - r.heartbeat_time;
                if (cfg.check_enable[ERR_TIMEOUT] && age > cfg.heartbeat_timeout)
                    tick_err[ERR_TIMEOUT] = 1'b1;
                if (cfg.check_enable[ERR_MODULE]) begin
                    if (r.fault_tally != 16'd0) begin
                        if (!pending[idx]) begin
                            pending[idx] = 1'b1;
                            started[idx] = r.now_ticks;
                        end
                        age = r.now_ticks - started[idx];
                        if (age >= cfg.fault_grace) begin
                            tick_err[ERR_MODULE] = 1'b1;
                            if (tick_fault == NO_MODULE)
                                tick_fault = {3'b000, idx};
                            tick_sum = SUM_FAULT;
                        end
                    end else begin
                        pending[idx] = 1'b0;
                    end
                    if (r.module_mode == MODE_FAULT)
                        tick_sum = SUM_FAULT;
                    else if (r.module_mode == MODE_BALANCING && tick_sum != SUM_FAULT)
                        tick_sum = SUM_BALANCING;
                end
            end
            if (!r.last_module) begin
                cursor = idx + 1'b1;
                return;
            end

            errs = tick_err;
            if (cfg.check_enable[ERR_OVERTEMP] && $signed(r.pack_temp) > $signed(cfg.temp_limit))
                errs[ERR_OVERTEMP] = 1'b1;
            if (cfg.check_enable[ERR_BATT_FLT] && r.batt_floating)
                errs[ERR_BATT_FLT] = 1'b1;
            if (cfg.check_enable[ERR_CURR_FLT] && r.current_floating)
                errs[ERR_CURR_FLT] = 1'b1;
            if (cfg.check_enable[ERR_BUS_A] && r.bus_a_error)
                errs[ERR_BUS_A] = 1'b1;
            if (cfg.check_enable[ERR_BUS_B] && r.bus_b_error)
                errs[ERR_BUS_B] = 1'b1;

            nxt = state;
            case (state)
                ST_PRE_INIT: begin
                    if (r.subsystems_ready)
                        nxt = (errs != '0) ? ST_ERRORED : ST_RUNNING;
                end
                ST_RUNNING: begin
                    if (errs != '0) begin
                        nxt = ST_ERRORED;
                    end else if (r.charge_request) begin
                        nxt        = ST_CHARGING;
                        idle_ticks = '0;
                    end
                end
                ST_CHARGING: begin
                    if (errs != '0 || idle_ticks > cfg.charge_idle_limit) begin
                        nxt = ST_ERRORED;
                    end else if (!r.charge_request) begin
                        // The watchdog count sticks at its top value.
                        if (idle_ticks != 8'hFF)
                            idle_ticks = idle_ticks + 8'd1;
                    end else begin
                        idle_ticks = '0;
                    end
                end
                default: begin
                    if (errs == '0)
                        nxt = ST_RUNNING;
                end
            endcase
            state = nxt;

            expected_status.push_back('{
                system_state:   nxt,
                error_mask:     errs,
                fault_module:   tick_fault,
                module_summary: tick_sum,
                fault_line_ok:  (nxt != ST_ERRORED)
            });
            ticks_closed++;
            cursor     = '0;
            tick_err   = '0;
            tick_fault = NO_MODULE;
            tick_sum   = SUM_IDLE;
        endfunction

        function void check_status(t_status got);
            t_status want;
            checked++;
            if (expected_status.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("Status word with none expected: state %0d mask %02h",
                             got.system_state, got.error_mask);
                    $display("  module %0d summary %0d line %0b",
                             got.fault_module, got.module_summary, got.fault_line_ok);
                end
                return;
            end
            want = expected_status.pop_front();
            if (got.system_state !== want.system_state || got.error_mask !== want.error_mask ||
                got.fault_module !== want.fault_module ||
                got.module_summary !== want.module_summary ||
                got.fault_line_ok !== want.fault_line_ok) begin
                failures++;
                if (failures <= 10) begin
                    $display("Status word %0d mismatch (expected/actual):", checked);
                    $display("  state %0d/%0d mask %02h/%02h module %0d/%0d",
                             want.system_state, got.system_state,
                             want.error_mask, got.error_mask,
                             want.fault_module, got.fault_module);
                    $display("  summary %0d/%0d line %0b/%0b",
                             want.module_summary, got.module_summary,
                             want.fault_line_ok, got.fault_line_ok);
                end
            end
        endfunction
    endclass

    logic                  i_clk              = 1'b0;
    logic                  i_rst_n            = 1'b0;
    logic                  i_cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx          = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data         = '0;
    logic                  i_in_valid         = 1'b0;
    logic [31:0]           i_now_ticks        = '0;
    logic [31:0]           i_heartbeat_time   = '0;
    logic [15:0]           i_fault_tally      = '0;
    logic [1:0]            i_module_mode      = '0;
    logic                  i_last_module      = 1'b0;
    logic signed [15:0]    i_pack_temp        = '0;
    logic                  i_batt_floating    = 1'b0;
    logic                  i_current_floating = 1'b0;
    logic                  i_bus_a_error      = 1'b0;
    logic                  i_bus_b_error      = 1'b0;
    logic                  i_subsystems_ready = 1'b0;
    logic                  i_charge_request   = 1'b0;
    logic                  i_out_stall        = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [1:0]            o_system_state;
    logic [ERR_W-1:0]      o_error_mask;
    logic [7:0]            o_fault_module;
    logic [1:0]            o_module_summary;
    logic                  o_fault_line_ok;

    status_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          charge_pct    = 30;
    int          ready_pct     = 90;
    int          flag_pct      = 3;
    bit          hold_req      = 1'b0;
    int          quiet_cycles  = 0;
    int          words_sent    = 0;
    int          settings_used = 0;
    logic [31:0] tick_now      = 32'hFFFF_FF00;
    bit          module_faulty[MODULES];

    battery_fault_supervisor #(.MODULES(MODULES)) DUT (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
    always @(posedge i_clk) begin : receiver
        int hold_left;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left    = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : status_monitor
        t_status seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = '{
                system_state:   t_sys_state'(o_system_state),
                error_mask:     o_error_mask,
                fault_module:   o_fault_module,
                module_summary: o_module_summary,
                fault_line_ok:  o_fault_line_ok
            };
            sb.check_status(seen);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input t_report r);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_now_ticks        <= r.now_ticks;
        i_heartbeat_time   <= r.heartbeat_time;
        i_fault_tally      <= r.fault_tally;
        i_module_mode      <= r.module_mode;
        i_last_module      <= r.last_module;
        i_pack_temp        <= r.pack_temp;
        i_batt_floating    <= r.batt_floating;
        i_current_floating <= r.current_floating;
        i_bus_a_error      <= r.bus_a_error;
        i_bus_b_error      <= r.bus_b_error;
        i_subsystems_ready <= r.subsystems_ready;
        i_charge_request   <= r.charge_request;
        i_in_valid         <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_word(r);
        words_sent++;
    endtask

    // Stops offering words and waits until every predicted status word has been seen.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CHECK_ENABLE;
        i_cfg_data <= {25'd0, c.check_enable};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TEMP_LIMIT;
        i_cfg_data <= {{16{c.temp_limit[15]}}, c.temp_limit};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HEARTBEAT_TIMEOUT;
        i_cfg_data <= c.heartbeat_timeout;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FAULT_GRACE;
        i_cfg_data <= c.fault_grace;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CHARGE_IDLE_LIMIT;
        i_cfg_data <= {24'd0, c.charge_idle_limit};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.cfg = c;
        settings_used++;
    endtask

    function automatic t_report plain_word(input logic [31:0] now, input logic [31:0] hb,
                                           input logic [15:0] faults, input logic [1:0] mode,
                                           input bit last);
        t_report r;
        r                  = '0;
        r.now_ticks        = now;
        r.heartbeat_time   = hb;
        r.fault_tally      = faults;
        r.module_mode      = mode;
        r.last_module      = last;
        r.subsystems_ready = 1'b1;
        return r;
    endfunction

    function automatic t_report random_word(input int pos, input bit last);
        t_report     r;
        logic [31:0] hb_lim;
        int          t;
        int          v;
        hb_lim      = sb.cfg.heartbeat_timeout;
        r.now_ticks = tick_now;
        case ($urandom_range(127))
            0:       r.heartbeat_time = $urandom;
            1:       r.heartbeat_time = tick_now - hb_lim;
            2:       r.heartbeat_time = tick_now - hb_lim - 32'd1;
            default: r.heartbeat_time = tick_now - $urandom_range(hb_lim);
        endcase
        if ((pos % 32) < MODULES && module_faulty[pos % 32])
            r.fault_tally = 16'($urandom_range(65535, 1));
        else if ($urandom_range(49) == 0)
            r.fault_tally = 16'($urandom);
        else
            r.fault_tally = '0;
        v = $urandom_range(99);
        r.module_mode = (v < 60) ? MODE_IDLE : (v < 80) ? MODE_BALANCING :
                        (v < 88) ? MODE_FAULT : MODE_OTHER;
        r.last_module = last;
        if (last) begin
            // Mostly just under the limit, sometimes on it, one above or anywhere.
            v = $urandom_range(19);
            if (v < 16)
                t = int'($signed(sb.cfg.temp_limit)) - int'($urandom_range(300));
            else if (v == 16)
                t = int'($signed(sb.cfg.temp_limit));
            else if (v == 17)
                t = int'($signed(sb.cfg.temp_limit)) + 1;
            else
                t = int'($signed(16'($urandom)));
            if (t < -32768) t = -32768;
            if (t > 32767) t = 32767;
            r.pack_temp        = t[15:0];
            r.batt_floating    = ($urandom_range(99) < flag_pct);
            r.current_floating = ($urandom_range(99) < flag_pct);
            r.bus_a_error      = ($urandom_range(99) < flag_pct);
            r.bus_b_error      = ($urandom_range(99) < flag_pct);
            r.subsystems_ready = ($urandom_range(99) < ready_pct);
            r.charge_request   = ($urandom_range(99) < charge_pct);
        end else begin
            // System flags on other words are ignored, so they carry noise.
            r.pack_temp        = 16'($urandom);
            r.batt_floating    = 1'($urandom_range(1));
            r.current_floating = 1'($urandom_range(1));
            r.bus_a_error      = 1'($urandom_range(1));
            r.bus_b_error      = 1'($urandom_range(1));
            r.subsystems_ready = 1'($urandom_range(1));
            r.charge_request   = 1'($urandom_range(1));
        end
        return r;
    endfunction

    function automatic int pick_len();
        int v;
        v = $urandom_range(99);
        if (v < 75) return MODULES;
        if (v < 87) return $urandom_range(MODULES - 1, 1);
        if (v < 98) return $urandom_range(MODULES + 4, MODULES + 1);
        return $urandom_range(40, 33);
    endfunction

    task automatic send_tick(input int len);
        for (int m = 0; m < MODULES; m++) begin
            if (module_faulty[m])
                module_faulty[m] = ($urandom_range(99) >= 15);
            else
                module_faulty[m] = ($urandom_range(99) < 5);
        end
        for (int k = 0; k < len; k++)
            send_word(random_word(k, k == len - 1));
        if ($urandom_range(99) == 0)
            tick_now = $urandom;
        else
            tick_now = tick_now + $urandom_range(4);
    endtask

    initial begin : stimulus
        t_report r;
        t_cfg    c;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed ticks on the reset settings.
        // Not ready: every system flag set, counter wrap on the heartbeat, fault pending.
        send_word(plain_word(32'hFFFF_FFFF, 32'h0, 16'hFFFF, MODE_FAULT, 1'b0));
        r = plain_word(32'hFFFF_FFFF, 32'h0, 16'h0001, MODE_OTHER, 1'b1);
        r.pack_temp        = 16'sh7FFF;
        r.batt_floating    = 1'b1;
        r.current_floating = 1'b1;
        r.bus_a_error      = 1'b1;
        r.bus_b_error      = 1'b1;
        r.subsystems_ready = 1'b0;
        r.charge_request   = 1'b1;
        send_word(r);
        r = plain_word(32'h0, 32'h0, 16'h0, MODE_BALANCING, 1'b1);
        r.pack_temp = 16'sh8000;
        send_word(r);
        r = plain_word(32'd1, 32'd1, 16'h0, MODE_OTHER, 1'b1);
        r.charge_request = 1'b1;
        send_word(r);
        send_word(plain_word(32'd2, 32'd2, 16'h0, MODE_IDLE, 1'b1));
        // A tick longer than the pack: the words past the last module take no part.
        for (int k = 0; k < MODULES + 2; k++) begin
            r = plain_word(32'd3, 32'd3, (k >= MODULES) ? 16'hFFFF : 16'h0,
                           (k >= MODULES) ? MODE_FAULT : MODE_BALANCING, k == MODULES + 1);
            r.charge_request = 1'b1;
            send_word(r);
        end
        r = plain_word(32'd4, 32'd4, 16'h0, MODE_IDLE, 1'b1);
        r.pack_temp      = 16'sd600;
        r.charge_request = 1'b1;
        send_word(r);
        r = plain_word(32'd4, 32'd4, 16'h0, MODE_IDLE, 1'b1);
        r.pack_temp = 16'sd601;
        send_word(r);
        send_word(plain_word(32'd5, 32'd5 - 32'd1000, 16'h0, MODE_IDLE, 1'b1));
        wait_drained();

        for (int p = 0; p < 9; p++) begin
            case (p)
                0: c = CFG_RESET;
                1: c = '{check_enable: 7'h7F, temp_limit: 16'h8000, heartbeat_timeout: 32'd0,
                         fault_grace: 32'd0, charge_idle_limit: 8'd0};
                2: c = '{check_enable: 7'h00, temp_limit: 16'h7FFF,
                         heartbeat_timeout: 32'hFFFF_FFFF, fault_grace: 32'hFFFF_FFFF,
                         charge_idle_limit: 8'd254};
                3: c = '{check_enable: 7'h6F, temp_limit: 16'sd250, heartbeat_timeout: 32'd50,
                         fault_grace: 32'd5, charge_idle_limit: 8'd3};
                4: c = '{check_enable: 7'h7F, temp_limit: 16'sd0, heartbeat_timeout: 32'd200,
                         fault_grace: 32'd3, charge_idle_limit: 8'd5};
                default: begin
                    c.check_enable      = ($urandom_range(1) == 1) ? 7'h7F :
                                          7'($urandom_range(127));
                    c.temp_limit        = 16'($urandom_range(900));
                    c.heartbeat_timeout = $urandom_range(3000);
                    c.fault_grace       = $urandom_range(12);
                    c.charge_idle_limit = 8'($urandom_range(30));
                end
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 56; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 56; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            apply_settings(c);
            // One tick long enough to wrap the module counter.
            if (p == 0)
                send_tick(34);
            for (int t = 0; t < 15; t++)
                send_tick(pick_len());
            wait_drained();
        end

        // Long receiver hold-off with the sender offering short ticks back to back,
        // so that the output word backs up and the input channel stalls.
        c = '{check_enable: 7'h7F, temp_limit: 16'sd600, heartbeat_timeout: 32'd1000,
              fault_grace: 32'd2, charge_idle_limit: 8'd10};
        apply_settings(c);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b1;
        for (int t = 0; t < 50; t++)
            send_tick($urandom_range(2, 1));
        wait_drained();

        // Charging with no requests until the idle watchdog runs out at its top limit.
        c = '{check_enable: 7'h00, temp_limit: 16'sd600, heartbeat_timeout: 32'd1000,
              fault_grace: 32'd1000, charge_idle_limit: 8'd254};
        apply_settings(c);
        ready_pct  = 100;
        charge_pct = 100;
        for (int t = 0; t < 2; t++)
            send_tick(1);
        charge_pct = 0;
        for (int t = 0; t < 258; t++)
            send_tick(1);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (sb.expected_status.size() != 0) begin
            $display("%0d status words never arrived", sb.expected_status.size());
            sb.failures += sb.expected_status.size();
        end
        $display("Sent %0d module words in %0d ticks over %0d register settings.",
                 words_sent, sb.ticks_closed, settings_used);
        $display("Checked %0d status words with no gaps, sender gaps, receiver stalls, both,",
                 sb.checked);
        $display("and a %0d-cycle receiver hold-off.", HOLD_CYCLES);
        if (sb.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
